/* src/sha256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 message hasher.
`timescale 1ns / 1ps

package sha256_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMP,
        S_FIN,
        S_PAD80,
        S_PADZ,
        S_PADL,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        BSEL_IN,
        BSEL_80,
        BSEL_ZERO,
        BSEL_LEN
    } t_bsel;

    typedef struct packed {
        logic       push;
        t_bsel      bsel;
        logic       count;
        logic [2:0] len_idx;
        logic       load_work;
        logic       round;
        logic [5:0] round_idx;
        logic       add_hash;
        logic       clear;
        logic [2:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_stat;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LAST_FILL = 6'd63;
    localparam logic [5:0] LEN_FILL = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD = 3'd7;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

/* src/sha256_dp.sv */
// Datapath: block shift buffer, message schedule, round logic, hash state, length.
`timescale 1ns / 1ps

module sha256_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha256_pkg::t_cmd   i_cmd,
    input  logic [7:0]         i_in_byte,
    output sha256_pkg::t_stat  o_stat,
    output logic [31:0]        o_word
);

    logic [511:0] r_blk;
    logic [31:0]  r_hash [8];
    logic [31:0]  r_work [8];
    logic [60:0]  r_total;
    logic [5:0]   r_fill;

    logic [63:0]  w_len_sh;
    logic [7:0]   w_byte;
    logic [31:0]  w_t;
    logic [31:0]  w_sched;
    logic [31:0]  w_ch;
    logic [31:0]  w_maj;
    logic [31:0]  w_t1;
    logic [31:0]  w_t2;

    assign w_len_sh = {r_total, 3'b000} << {i_cmd.len_idx, 3'b000};

    always_comb begin
        case (i_cmd.bsel)
            sha256_pkg::BSEL_IN:   w_byte = i_in_byte;
            sha256_pkg::BSEL_80:   w_byte = sha256_pkg::PAD_BYTE;
            sha256_pkg::BSEL_ZERO: w_byte = 8'd0;
            sha256_pkg::BSEL_LEN:  w_byte = w_len_sh[63:56];
            default:               w_byte = 8'd0;
        endcase
    end

    assign w_t     = r_blk[511:480];
    assign w_sched = sha256_pkg::f_ssig1(r_blk[63:32]) + r_blk[223:192]
                   + sha256_pkg::f_ssig0(r_blk[479:448]) + w_t;
    assign w_ch    = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
    assign w_maj   = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2])
                   ^ (r_work[1] & r_work[2]);
    assign w_t1    = r_work[7] + sha256_pkg::f_bsig1(r_work[4]) + w_ch
                   + sha256_pkg::K_TABLE[i_cmd.round_idx] + w_t;
    assign w_t2    = sha256_pkg::f_bsig0(r_work[0]) + w_maj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_fill  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= sha256_pkg::IV[i];
            end
        end else begin
            if (i_cmd.clear) begin
                r_total <= '0;
                r_fill  <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= sha256_pkg::IV[i];
                end
            end else begin
                if (i_cmd.push) begin
                    r_fill <= r_fill + 6'd1;
                end
                if (i_cmd.count) begin
                    r_total <= r_total + 61'd1;
                end
                if (i_cmd.add_hash) begin
                    for (int i = 0; i < 8; i++) begin
                        r_hash[i] <= r_hash[i] + r_work[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_blk <= {r_blk[503:0], w_byte};
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[479:0], w_sched};
        end
        if (i_cmd.load_work) begin
            for (int i = 0; i < 8; i++) begin
                r_work[i] <= r_hash[i];
            end
        end else if (i_cmd.round) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + w_t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= w_t1 + w_t2;
        end
    end

    assign o_stat.fill = r_fill;
    assign o_word      = r_hash[i_cmd.out_idx];

endmodule

/* src/sha256_ctrl.sv */
// Controller: absorb, padding, round sequencing and digest output state machine.
`timescale 1ns / 1ps

module sha256_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    input  logic               i_in_nodata,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_out_last,
    output logic [2:0]         o_out_idx,
    output sha256_pkg::t_cmd   o_cmd,
    input  sha256_pkg::t_stat  i_stat
);

    sha256_pkg::t_state r_state, n_state;
    sha256_pkg::t_state r_ret, n_ret;
    logic [5:0] r_cnt, n_cnt;
    logic [2:0] r_lcnt, n_lcnt;
    logic [2:0] r_oidx, n_oidx;
    logic       w_full;

    assign w_full = (i_stat.fill == sha256_pkg::LAST_FILL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::S_IDLE;
            r_ret   <= sha256_pkg::S_IDLE;
            r_cnt   <= '0;
            r_lcnt  <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_lcnt  <= n_lcnt;
            r_oidx  <= n_oidx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_cnt       = r_cnt;
        n_lcnt      = r_lcnt;
        n_oidx      = r_oidx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.bsel  = sha256_pkg::BSEL_IN;
        o_cmd.round_idx = r_cnt;
        o_cmd.len_idx   = r_lcnt;
        o_cmd.out_idx   = r_oidx;
        case (r_state)
            sha256_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_in_nodata) begin
                        o_cmd.push  = 1'b1;
                        o_cmd.count = 1'b1;
                    end
                    if (!i_in_nodata && w_full) begin
                        o_cmd.load_work = 1'b1;
                        n_state = sha256_pkg::S_COMP;
                        n_ret   = i_in_last ? sha256_pkg::S_PAD80 : sha256_pkg::S_IDLE;
                    end else if (i_in_last) begin
                        n_state = sha256_pkg::S_PAD80;
                    end
                end
            end
            sha256_pkg::S_COMP: begin
                o_cmd.round = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == sha256_pkg::LAST_ROUND) begin
                    n_state = sha256_pkg::S_FIN;
                end
            end
            sha256_pkg::S_FIN: begin
                o_cmd.add_hash = 1'b1;
                n_state = r_ret;
            end
            sha256_pkg::S_PAD80: begin
                o_cmd.push = 1'b1;
                o_cmd.bsel = sha256_pkg::BSEL_80;
                n_state = sha256_pkg::S_PADZ;
                if (w_full) begin
                    o_cmd.load_work = 1'b1;
                    n_state = sha256_pkg::S_COMP;
                    n_ret   = sha256_pkg::S_PADZ;
                end
            end
            sha256_pkg::S_PADZ: begin
                if (i_stat.fill == sha256_pkg::LEN_FILL) begin
                    n_state = sha256_pkg::S_PADL;
                end else begin
                    o_cmd.push = 1'b1;
                    o_cmd.bsel = sha256_pkg::BSEL_ZERO;
                    if (w_full) begin
                        o_cmd.load_work = 1'b1;
                        n_state = sha256_pkg::S_COMP;
                        n_ret   = sha256_pkg::S_PADZ;
                    end
                end
            end
            sha256_pkg::S_PADL: begin
                o_cmd.push = 1'b1;
                o_cmd.bsel = sha256_pkg::BSEL_LEN;
                n_lcnt = r_lcnt + 3'd1;
                if (r_lcnt == sha256_pkg::LAST_WORD) begin
                    o_cmd.load_work = 1'b1;
                    n_state = sha256_pkg::S_COMP;
                    n_ret   = sha256_pkg::S_OUT;
                end
            end
            sha256_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == sha256_pkg::LAST_WORD) begin
                        o_cmd.clear = 1'b1;
                        n_state = sha256_pkg::S_IDLE;
                        n_ret   = sha256_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sha256_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_last = (r_oidx == sha256_pkg::LAST_WORD);
    assign o_out_idx  = r_oidx;

    a_fin_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::S_COMP && r_cnt == sha256_pkg::LAST_ROUND)
        |=> (r_state == sha256_pkg::S_FIN))
        else $error("compression did not finish after the last round");

    a_load_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.push && w_full) |-> (o_cmd.load_work && n_state == sha256_pkg::S_COMP))
        else $error("full block not sent to compression");

    a_len_at_56: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::S_PADL && r_lcnt == 3'd0)
        |-> (i_stat.fill == sha256_pkg::LEN_FILL))
        else $error("length field misplaced in the block");

    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_in_ready && !o_cmd.push && !o_cmd.round))
        else $error("digest output overlaps with block work");

endmodule

/* src/sha256_message_hasher.sv */
// Top level of the SHA-256 message hasher: byte stream in, digest words out.
//
//  channel   | dir | tdata              | tuser          | tlast
//  s_axis    | in  | [7:0] data_byte    | [0] no_data    | is_last
//  m_axis    | out | [31:0] digest_word | [2:0] word_idx | last_word
//
// Bytes are taken only while idle; a byte that completes a 64-byte block
// starts 64 rounds on the single round unit, then the hash update.
// The last item is followed by up to 72 padding bytes (0x80, zeros, 64-bit
// length), a check state ahead of the length field and one or two
// compressions, then eight digest transfers; no input is taken meanwhile.
// Reset is synchronous; a stalled m_axis holds the block in the output state.
`timescale 1ns / 1ps

module sha256_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,   // [0] no_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser    // [2:0] word_index
);

    sha256_pkg::t_cmd  w_cmd;
    sha256_pkg::t_stat w_stat;

    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .i_in_nodata (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_last  (m_axis_tlast),
        .o_out_idx   (m_axis_tuser),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    sha256_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_in_byte (s_axis_tdata),
        .o_stat    (w_stat),
        .o_word    (m_axis_tdata)
    );

endmodule
